FILE: hdl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared widths, latencies and item types of the distance constraint
// projection engine.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int PosW     = 32;            // Q16.16 coordinate and result width
  localparam int MassW    = 31;            // inverse mass and rest length
  localparam int TsW      = 17;            // time step register
  localparam int DiffW    = 33;            // p0 - p1, also its magnitude
  localparam int SqW      = 2 * DiffW;     // sum of squares
  localparam int LenW     = SqW / 2;       // integer square root
  localparam int MagW     = 33;            // |rest - len|, |f|, |corr|
  localparam int KW       = 17;            // mass ratio and unit vector, <= 1.0
  localparam int VqW      = 31;            // velocity quotient below saturation
  localparam int FracW    = 16;
  localparam int InDataW  = 288;
  localparam int OutDataW = 12 * PosW;

  localparam logic [TsW-1:0] TsReset = 17'd1092;

  localparam int SqrtLat  = LenW;
  localparam int NDivLat  = KW;
  localparam int VDivLat  = VqW;
  localparam int BackLat  = 2 + SqrtLat + NDivLat + 2 + VDivLat + 1;

  localparam int QueueDepthDef = 4;

  typedef struct packed {
    logic                      mass_zero;
    logic [MassW-1:0]          rest;
    logic [MassW-1:0]          w1;
    logic [MassW-1:0]          w0;
    logic [2:0][PosW-1:0]      p1;
    logic [2:0][PosW-1:0]      p0;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: hdl/distance_constraint_projection.sv
// ----------------------------------------------------------------------------
// distance_constraint_projection
// Fixed-point distance constraint projection: corrections and velocity
// changes for both bodies of one constraint per beat.
// ----------------------------------------------------------------------------
// Takes one constraint beat per clock and returns one result beat per clock
// in the same order while the output is taken. A beat waits in the input
// queue and then passes the arithmetic pipeline, built around the 33-stage
// square root, the 17-stage unit-vector and mass-ratio dividers and the
// 31-stage velocity dividers. The whole arithmetic pipeline holds while the
// output is not taken; the input queue keeps accepting until it is full.
// time_step may be written only while no beat is in flight.
module distance_constraint_projection import dcp_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TsW-1:0]      cfg_wdata_i,    // time_step, unsigned Q1.16
  input  logic                s_tvalid,
  output logic                s_tready,
  // first_pos_x/y/z, second_pos_x/y/z, first_inv_mass, second_inv_mass,
  // rest_length, zero pad
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // first_corr_x/y/z, second_corr_x/y/z, first_dvel_x/y/z, second_dvel_x/y/z
  output logic [OutDataW-1:0] m_tdata
);

  logic [TsW-1:0] ts_q;
  q_stat_t        q_stat;
  item_t          push_item, head_item;
  logic           push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ts_q <= TsReset;
    else if (cfg_we_i) ts_q <= cfg_wdata_i;
  end

  dcp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  dcp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .stat_o (q_stat),
    .item_o (head_item)
  );

  dcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .time_step_i (ts_q),
    .q_stat_i    (q_stat),
    .q_item_i    (head_item),
    .q_pop_o     (pop),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata)
  );

endmodule

FILE: hdl/dcp_front.sv
// ----------------------------------------------------------------------------
// dcp_front
// Input side: unpacks a constraint beat, flags the massless case and pushes
// it into the queue whenever there is room.
// ----------------------------------------------------------------------------
module dcp_front import dcp_pkg::*; (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,
  input  q_stat_t            q_stat_i,
  output logic               push_o,
  output item_t              item_o
);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_o.p0[i] = s_tdata[PosW*i +: PosW];
      item_o.p1[i] = s_tdata[PosW*(3+i) +: PosW];
    end
    item_o.w0        = s_tdata[6*PosW +: MassW];
    item_o.w1        = s_tdata[6*PosW+MassW +: MassW];
    item_o.rest      = s_tdata[6*PosW+2*MassW +: MassW];
    item_o.mass_zero = (item_o.w0 == '0) && (item_o.w1 == '0);
  end

  assign s_tready = !q_stat_i.full;
  assign push_o   = s_tvalid && !q_stat_i.full;

endmodule

FILE: hdl/dcp_queue.sv
// ----------------------------------------------------------------------------
// dcp_queue
// Small FIFO between the input side and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module dcp_queue import dcp_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output q_stat_t stat_o,
  output item_t   item_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(Depth));

endmodule

FILE: hdl/dcp_div.sv
// ----------------------------------------------------------------------------
// dcp_div
// Pipelined restoring divider, one quotient bit per stage. Needs a < b<<QW.
// ----------------------------------------------------------------------------
module dcp_div #(
  parameter int AW = 49,
  parameter int BW = 33,
  parameter int QW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [QW-1:0] q_o
);

  localparam int W = (AW > BW + QW) ? AW : BW + QW;

  logic [W-1:0]  r_q [QW-1];
  logic [BW-1:0] b_q [QW-1];
  logic [QW-1:0] q_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W-1:0]  r_in, thr;
    logic [BW-1:0] b_in;
    logic [QW-1:0] q_in;
    logic          hit;

    if (k == 0) begin : g_first
      assign r_in = W'(a_i);
      assign b_in = b_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign b_in = b_q[k-1];
      assign q_in = q_q[k-1];
    end

    assign thr = W'(b_in) << (QW - 1 - k);
    assign hit = (r_in >= thr);

    always_ff @(posedge clk_i) begin
      if (en_i) q_q[k] <= q_in | (QW'(hit) << (QW - 1 - k));
    end

    if (k < QW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k] <= hit ? r_in - thr : r_in;
          b_q[k] <= b_in;
        end
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

FILE: hdl/dcp_sqrt.sv
// ----------------------------------------------------------------------------
// dcp_sqrt
// Pipelined integer square root, two radicand bits per stage.
// ----------------------------------------------------------------------------
module dcp_sqrt #(
  parameter int SW = 66
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SW-1:0]   rad_i,
  output logic [SW/2-1:0] root_o
);

  localparam int RtW  = SW / 2;
  localparam int RemW = RtW + 2;

  logic [RemW-1:0] rem_q  [RtW];
  logic [RtW-1:0]  root_q [RtW];
  logic [SW-1:0]   rad_q  [RtW-1];

  for (genvar k = 0; k < RtW; k++) begin : g_stage
    logic [RemW-1:0] rem_in, rem_sh, trial;
    logic [RtW-1:0]  root_in;
    logic [SW-1:0]   rad_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], rad_in[SW-1-2*k -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[RtW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[RtW-2:0], 1'b0};
        end
      end
    end

    if (k < RtW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) rad_q[k] <= rad_in;
      end
    end
  end

  assign root_o = root_q[RtW-1];

endmodule

FILE: hdl/dcp_back.sv
// ----------------------------------------------------------------------------
// dcp_back
// Arithmetic pipeline: difference, length, mass ratio, corrections and
// velocity changes, saturated into the output register. Stalls as a whole.
// ----------------------------------------------------------------------------
module dcp_back import dcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TsW-1:0]      time_step_i,
  input  q_stat_t             q_stat_i,
  input  item_t               q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  typedef struct packed {
    logic                   mzero;
    logic [MassW-1:0]       rest;
    logic [MassW-1:0]       w1;
    logic [MassW-1:0]       w0;
    logic [2:0]             dneg;
    logic [2:0][DiffW-1:0]  dmag;
  } side_t;

  typedef struct packed {
    logic             zero;
    logic             eneg;
    logic [MagW-1:0]  emag;
    logic [2:0]       dneg;
  } mid_t;

  typedef struct packed {
    logic                  zero;
    logic                  tz;
    logic [5:0]            ovf;
    logic [5:0]            cneg;
    logic [5:0][MagW-1:0]  cmag;
  } late_t;

  function automatic logic [PosW-1:0] sat_corr(logic neg, logic [MagW-1:0] m);
    logic [PosW-1:0] r;
    if (m[MagW-1:PosW-1] != '0) r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else                        r = neg ? 32'd0 - m[PosW-1:0] : m[PosW-1:0];
    return r;
  endfunction

  logic               en;
  logic [BackLat-1:0] vld_q;

  assign en      = !vld_q[BackLat-1] || out_ready_i;
  assign q_pop_o = en && !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[BackLat-2:0], !q_stat_i.empty};
  end

  // difference and squares
  side_t            s1_c, s1_q, s2_q;
  logic [SqW-1:0]   sq_c [3];
  logic [SqW-1:0]   sq_q [3];
  logic [SqW-1:0]   rad_q;

  always_comb begin
    logic signed [DiffW-1:0] d;
    s1_c.mzero = q_item_i.mass_zero;
    s1_c.rest  = q_item_i.rest;
    s1_c.w0    = q_item_i.w0;
    s1_c.w1    = q_item_i.w1;
    for (int i = 0; i < 3; i++) begin
      d = $signed({q_item_i.p0[i][PosW-1], q_item_i.p0[i]})
        - $signed({q_item_i.p1[i][PosW-1], q_item_i.p1[i]});
      s1_c.dneg[i] = d[DiffW-1];
      s1_c.dmag[i] = d[DiffW-1] ? DiffW'(0) - d : d;
      sq_c[i]      = SqW'(s1_c.dmag[i]) * SqW'(s1_c.dmag[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_c;
      for (int i = 0; i < 3; i++) sq_q[i] <= sq_c[i];
      s2_q  <= s1_q;
      rad_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // length
  logic [LenW-1:0] len;
  side_t           sd_q [SqrtLat];

  dcp_sqrt #(.SW(SqW)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (len)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= s2_q;
      for (int k = 1; k < SqrtLat; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // unit vector and mass ratios
  side_t                 s3;
  mid_t                  m3_c;
  logic signed [MagW:0]  e_c;
  logic [MassW:0]        wsum;
  logic [KW-1:0]         k0, k1;
  logic [2:0][KW-1:0]    n_w;
  mid_t                  md_q [NDivLat];

  assign s3   = sd_q[SqrtLat-1];
  assign wsum = {1'b0, s3.w0} + {1'b0, s3.w1};
  assign e_c  = $signed({3'b000, s3.rest}) - $signed({1'b0, len});

  always_comb begin
    m3_c.zero = s3.mzero || (len == '0);
    m3_c.eneg = e_c[MagW];
    m3_c.emag = e_c[MagW] ? MagW'(0) - e_c[MagW-1:0] : e_c[MagW-1:0];
    m3_c.dneg = s3.dneg;
  end

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    dcp_div #(.AW(DiffW + FracW), .BW(LenW), .QW(KW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ({s3.dmag[i], {FracW{1'b0}}}),
      .b_i   (len),
      .q_o   (n_w[i])
    );
  end

  dcp_div #(.AW(MassW + FracW), .BW(MassW + 1), .QW(KW)) u_k0 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ({s3.w0, {FracW{1'b0}}}),
    .b_i   (wsum),
    .q_o   (k0)
  );

  dcp_div #(.AW(MassW + FracW), .BW(MassW + 1), .QW(KW)) u_k1 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ({s3.w1, {FracW{1'b0}}}),
    .b_i   (wsum),
    .q_o   (k1)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= m3_c;
      for (int k = 1; k < NDivLat; k++) md_q[k] <= md_q[k-1];
    end
  end

  // f = k * e, then c = f * n
  mid_t                  m4, f_side_q, c_side_q;
  logic [KW+MagW-1:0]    p0_c, p1_c;
  logic [MagW-1:0]       f0_q, f1_q;
  logic [2:0][KW-1:0]    n_q;
  logic [5:0][MagW-1:0]  cmag_c, cmag_q;
  logic [5:0]            cneg_c, cneg_q;

  assign m4   = md_q[NDivLat-1];
  assign p0_c = (KW+MagW)'(k0) * (KW+MagW)'(m4.emag);
  assign p1_c = (KW+MagW)'(k1) * (KW+MagW)'(m4.emag);

  always_comb begin
    logic [KW+MagW-1:0] pa, pb;
    for (int i = 0; i < 3; i++) begin
      pa            = (KW+MagW)'(f0_q) * (KW+MagW)'(n_q[i]);
      pb            = (KW+MagW)'(f1_q) * (KW+MagW)'(n_q[i]);
      cmag_c[i]     = pa[MagW+FracW-1:FracW];
      cmag_c[3+i]   = pb[MagW+FracW-1:FracW];
      cneg_c[i]     = f_side_q.eneg ^ f_side_q.dneg[i];
      cneg_c[3+i]   = !(f_side_q.eneg ^ f_side_q.dneg[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_q     <= p0_c[MagW+FracW-1:FracW];
      f1_q     <= p1_c[MagW+FracW-1:FracW];
      n_q      <= n_w;
      f_side_q <= m4;
      cmag_q   <= cmag_c;
      cneg_q   <= cneg_c;
      c_side_q <= f_side_q;
    end
  end

  // velocity change: |c| * 2^16 / time_step, overflow caught up front
  late_t               l5_c;
  late_t               ld_q [VDivLat];
  logic [5:0][VqW-1:0] vq_w;

  always_comb begin
    l5_c.zero = c_side_q.zero;
    l5_c.tz   = (time_step_i == '0);
    l5_c.cmag = cmag_q;
    l5_c.cneg = cneg_q;
    for (int j = 0; j < 6; j++) begin
      l5_c.ovf[j] = cmag_q[j] >= MagW'({time_step_i, 15'b0});
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_vdiv
    dcp_div #(.AW(MagW + FracW), .BW(TsW), .QW(VqW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ({cmag_q[j], {FracW{1'b0}}}),
      .b_i   (time_step_i),
      .q_o   (vq_w[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ld_q[0] <= l5_c;
      for (int k = 1; k < VDivLat; k++) ld_q[k] <= ld_q[k-1];
    end
  end

  // saturate into the output register
  late_t                 l6;
  logic [11:0][PosW-1:0] out_c, out_q;

  assign l6 = ld_q[VDivLat-1];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      if (l6.zero) begin
        out_c[j]   = '0;
        out_c[6+j] = '0;
      end else begin
        out_c[j] = sat_corr(l6.cneg[j], l6.cmag[j]);
        if (l6.tz)          out_c[6+j] = '0;
        else if (l6.ovf[j]) out_c[6+j] = l6.cneg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (l6.cneg[j]) out_c[6+j] = 32'd0 - {1'b0, vq_w[j]};
        else                 out_c[6+j] = {1'b0, vq_w[j]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_c;
  end

  assign out_valid_o = vld_q[BackLat-1];
  assign out_data_o  = out_q;

endmodule

FILE: hdl/dcp_checker.sv
// ----------------------------------------------------------------------------
// dcp_checker
// Port-level checks: output hold under stall and beat accounting.
// ----------------------------------------------------------------------------
module dcp_checker import dcp_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  localparam logic [15:0] Cap = 16'(QueueDepth + BackLat);

  logic [15:0] cnt_q;
  logic        in_acc, out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (in_acc && !out_acc) cnt_q <= cnt_q + 1'b1;
    else if (out_acc && !in_acc) cnt_q <= cnt_q - 1'b1;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> cnt_q != 16'd0)
    else $error("result beat without an accepted input");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Cap)
    else $error("more beats in flight than the engine can hold");

endmodule

bind distance_constraint_projection dcp_checker #(.QueueDepth(QueueDepth)) u_dcp_checker (.*);
